### rtl/afc_pkg.sv
`timescale 1ns / 1ps

package afc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int COORD_W    = 28;
  localparam int HALF_W     = 27;
  localparam int NORM_W     = 12;
  localparam int OFF_W      = 28;
  localparam int OFF_SHIFT  = 10;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int PROD_C_W   = COORD_W + NORM_W;
  localparam int PROD_H_W   = HALF_W + NORM_W;
  localparam int SUM_W      = 44;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_DOWN  = 3'd0,
    REG_PLANE_TOP   = 3'd1,
    REG_PLANE_RIGHT = 3'd2,
    REG_PLANE_LEFT  = 3'd3,
    REG_PLANE_NEAR  = 3'd4,
    REG_PLANE_FAR   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [OFF_W-1:0]  offset;
    logic signed [NORM_W-1:0] nz;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nx;
  } plane_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic [HALF_W-1:0]         hx;
    logic [HALF_W-1:0]         hy;
    logic [HALF_W-1:0]         hz;
  } box_t;

endpackage

### rtl/afc_plane_test.sv
`timescale 1ns / 1ps

module afc_plane_test (
  input  logic            clk,
  input  afc_pkg::plane_t plane,
  input  afc_pkg::box_t   box,
  output logic            pass
);

  logic [afc_pkg::NORM_W-1:0] abs_x, abs_y, abs_z;

  logic signed [afc_pkg::PROD_C_W-1:0] pc_x_nxt, pc_y_nxt, pc_z_nxt;
  logic signed [afc_pkg::PROD_C_W-1:0] pc_x_r, pc_y_r, pc_z_r;
  logic [afc_pkg::PROD_H_W-1:0]        ph_x_nxt, ph_y_nxt, ph_z_nxt;
  logic [afc_pkg::PROD_H_W-1:0]        ph_x_r, ph_y_r, ph_z_r;
  logic signed [afc_pkg::OFF_W-1:0]    off_r;
  logic signed [afc_pkg::SUM_W-1:0]    sum;

  // |-2048| is 2048, which still fits 12 bits unsigned
  assign abs_x = plane.nx[afc_pkg::NORM_W-1] ? -plane.nx : plane.nx;
  assign abs_y = plane.ny[afc_pkg::NORM_W-1] ? -plane.ny : plane.ny;
  assign abs_z = plane.nz[afc_pkg::NORM_W-1] ? -plane.nz : plane.nz;

  assign pc_x_nxt = box.cx * plane.nx;
  assign pc_y_nxt = box.cy * plane.ny;
  assign pc_z_nxt = box.cz * plane.nz;
  assign ph_x_nxt = box.hx * abs_x;
  assign ph_y_nxt = box.hy * abs_y;
  assign ph_z_nxt = box.hz * abs_z;

  always_ff @(posedge clk) begin
    pc_x_r <= pc_x_nxt;
    pc_y_r <= pc_y_nxt;
    pc_z_r <= pc_z_nxt;
    ph_x_r <= ph_x_nxt;
    ph_y_r <= ph_y_nxt;
    ph_z_r <= ph_z_nxt;
    off_r  <= plane.offset;
  end

  // -r <= d  is  d + r >= 0
  always_comb begin
    sum = { {(afc_pkg::SUM_W-afc_pkg::OFF_W-afc_pkg::OFF_SHIFT){off_r[afc_pkg::OFF_W-1]}},
            off_r, {afc_pkg::OFF_SHIFT{1'b0}} }
        + afc_pkg::SUM_W'(pc_x_r) + afc_pkg::SUM_W'(pc_y_r) + afc_pkg::SUM_W'(pc_z_r)
        + $signed({{(afc_pkg::SUM_W-afc_pkg::PROD_H_W){1'b0}}, ph_x_r})
        + $signed({{(afc_pkg::SUM_W-afc_pkg::PROD_H_W){1'b0}}, ph_y_r})
        + $signed({{(afc_pkg::SUM_W-afc_pkg::PROD_H_W){1'b0}}, ph_z_r});
  end

  assign pass = ~sum[afc_pkg::SUM_W-1];

endmodule

### rtl/aabb_frustum_cull.sv
`timescale 1ns / 1ps
// Ordering: out_valid and out_visible are registered together in the result register.
// Throughput: one box per cycle; busy is never raised and the receiver cannot stall.
// Stages: input register, plane products register, sum/compare into result register.
// Reset (rst_n low, synchronous): pipeline emptied, all plane registers zeroed.

module aabb_frustum_cull (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [afc_pkg::COORD_W-1:0]  in_center_x,
  input  logic signed [afc_pkg::COORD_W-1:0]  in_center_y,
  input  logic signed [afc_pkg::COORD_W-1:0]  in_center_z,
  input  logic [afc_pkg::HALF_W-1:0]          in_half_x,
  input  logic [afc_pkg::HALF_W-1:0]          in_half_y,
  input  logic [afc_pkg::HALF_W-1:0]          in_half_z,
  output logic                                out_valid,
  output logic                                out_visible,
  input  logic                                cfg_we,
  input  logic [afc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [afc_pkg::CFG_W-1:0]           cfg_data
);

  afc_pkg::plane_t plane_r [afc_pkg::NUM_PLANES];
  afc_pkg::box_t   box_r;
  logic            in_valid_r, prod_valid_r, out_valid_r, out_visible_r;
  logic [afc_pkg::NUM_PLANES-1:0] pass;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < afc_pkg::NUM_PLANES; i++) begin
        plane_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        afc_pkg::REG_PLANE_DOWN:  plane_r[0] <= afc_pkg::plane_t'(cfg_data);
        afc_pkg::REG_PLANE_TOP:   plane_r[1] <= afc_pkg::plane_t'(cfg_data);
        afc_pkg::REG_PLANE_RIGHT: plane_r[2] <= afc_pkg::plane_t'(cfg_data);
        afc_pkg::REG_PLANE_LEFT:  plane_r[3] <= afc_pkg::plane_t'(cfg_data);
        afc_pkg::REG_PLANE_NEAR:  plane_r[4] <= afc_pkg::plane_t'(cfg_data);
        afc_pkg::REG_PLANE_FAR:   plane_r[5] <= afc_pkg::plane_t'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      box_r <= '{cx: in_center_x, cy: in_center_y, cz: in_center_z,
                 hx: in_half_x,   hy: in_half_y,   hz: in_half_z};
    end
    out_visible_r <= &pass;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      prod_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      in_valid_r   <= start && !busy;
      prod_valid_r <= in_valid_r;
      out_valid_r  <= prod_valid_r;
    end
  end

  for (genvar g = 0; g < afc_pkg::NUM_PLANES; g++) begin : g_plane
    afc_plane_test u_plane (
      .clk   (clk),
      .plane (plane_r[g]),
      .box   (box_r),
      .pass  (pass[g])
    );
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

endmodule

### rtl/afc_checker.sv
`timescale 1ns / 1ps

module afc_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("accepted beat gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 3))
    else $error("result without accepted beat");

  a_reset_flush: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
